>>> sv/cbst_pkg.sv
// Cubic Bezier segment tessellator: shared constants, register codes and types.
// No dependencies; every other file of the block imports this package.
package cbst_pkg;

	localparam int MAX_SEG_PTS_DEF = 64;
	localparam int COORD_W_DEF     = 16;

	localparam int NPTS   = 4;
	localparam int NAXIS  = 3;
	localparam int NCOORD = NPTS * NAXIS;

	localparam int T_W = 17;
	localparam logic [T_W-1:0] T_ONE = 17'h10000;

	localparam int IDX_W  = 6;
	localparam int SP_W   = 7;
	localparam int STEP_W = 17;
	localparam logic [SP_W-1:0]   SP_RESET   = 7'd64;
	localparam logic [STEP_W-1:0] STEP_RESET = 17'd1024;

	// Bernstein weights are Q1.48, split into high and low parts for the products
	localparam int W_W     = 49;
	localparam int W_FRAC  = 48;
	localparam int W_SPLIT = 24;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEGMENT_POINTS = 4'd0,
		REG_PARAM_STEP     = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
	} tag_t;

endpackage

>>> sv/cbst_intf.sv
// Cubic Bezier segment tessellator: channel interfaces (segment in, point out, config).
// Depends on cbst_pkg.
interface cbst_seg_if #(parameter int CW = cbst_pkg::COORD_W_DEF);
	logic valid;
	logic ready;
	logic signed [CW-1:0] p0_x, p0_y, p0_z;
	logic signed [CW-1:0] p1_x, p1_y, p1_z;
	logic signed [CW-1:0] p2_x, p2_y, p2_z;
	logic signed [CW-1:0] p3_x, p3_y, p3_z;

	modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
	modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface cbst_pt_if #(parameter int CW = cbst_pkg::COORD_W_DEF);
	import cbst_pkg::*;
	logic valid;
	logic ready;
	logic signed [CW-1:0] point_x, point_y, point_z;
	logic [IDX_W-1:0] point_index;
	logic last_point;

	modport source (output valid, point_x, point_y, point_z, point_index, last_point,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, point_index, last_point,
		output ready);
endinterface

interface cbst_cfg_if;
	import cbst_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/cubic_bezier_segment_tessellator_top.sv
// Cubic Bezier segment tessellator: top level, configuration registers and pipeline wiring.
// Depends on cbst_pkg, the cbst interfaces, cbst_seq, cbst_weight and cbst_blend.

// One segment item (four 3-D control points, signed Q2.14) yields N point items, N being
// segment_points clamped to 1..MAX_SEGMENT_POINTS, at t = j * param_step (Q1.16, held at 1.0).
// The sequencer issues one t per cycle unless the pipeline stalls, and the next segment is taken
// on the cycle its predecessor's last point issues; with the output always ready the block
// delivers one point per clock. There are six register stages from issue to the output register
// (s1 to s6: issue, squares, cubes, partial products, sums, round and saturate). Output stalls
// hold the pipeline without loss. Configuration writes are always taken and are meant for idle
// periods.
module cubic_bezier_segment_tessellator_top #(
	parameter int MAX_SEGMENT_POINTS = cbst_pkg::MAX_SEG_PTS_DEF,
	parameter int COORD_WIDTH        = cbst_pkg::COORD_W_DEF
) (
	input logic clk,
	input logic arst_n,
	cbst_seg_if.sink seg,
	cbst_pt_if.source pt,
	cbst_cfg_if.sink cfg
);
	import cbst_pkg::*;

	logic [SP_W-1:0] seg_pts_q;
	logic [STEP_W-1:0] step_q;

	logic v_s1, rdy_s1, v_s3, rdy_s3;
	logic [T_W-1:0] t_s1, u_s1;
	tag_t tag_s1, tag_s3;
	logic signed [COORD_WIDTH-1:0] coords_s1 [NCOORD];
	logic signed [COORD_WIDTH-1:0] coords_s3 [NCOORD];
	logic [W_W-1:0] w_s3 [NPTS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_pts_q <= SP_RESET;
			step_q    <= STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SEGMENT_POINTS: seg_pts_q <= cfg.data[SP_W-1:0];
				REG_PARAM_STEP:     step_q    <= cfg.data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	cbst_seq #(
		.MAX_SEGMENT_POINTS(MAX_SEGMENT_POINTS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.seg(seg),
		.seg_pts(seg_pts_q),
		.step(step_q),
		.v_s1(v_s1),
		.rdy_s1(rdy_s1),
		.t_s1(t_s1),
		.u_s1(u_s1),
		.tag_s1(tag_s1),
		.coords_s1(coords_s1)
	);

	cbst_weight #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_weight (
		.clk(clk),
		.arst_n(arst_n),
		.v_s1(v_s1),
		.rdy_s1(rdy_s1),
		.t_s1(t_s1),
		.u_s1(u_s1),
		.tag_s1(tag_s1),
		.coords_s1(coords_s1),
		.v_s3(v_s3),
		.rdy_s3(rdy_s3),
		.w_s3(w_s3),
		.tag_s3(tag_s3),
		.coords_s3(coords_s3)
	);

	cbst_blend #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.v_s3(v_s3),
		.rdy_s3(rdy_s3),
		.w_s3(w_s3),
		.tag_s3(tag_s3),
		.coords_s3(coords_s3),
		.pt(pt)
	);

endmodule

>>> sv/cbst_seq.sv
// Cubic Bezier segment tessellator: sequencer, holds the segment, issues one t per unstalled cycle.
// Depends on cbst_pkg and cbst_seg_if; feeds cbst_weight (stage s1).
module cbst_seq #(
	parameter int MAX_SEGMENT_POINTS = cbst_pkg::MAX_SEG_PTS_DEF,
	parameter int COORD_WIDTH        = cbst_pkg::COORD_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cbst_seg_if.sink seg,
	input  logic [cbst_pkg::SP_W-1:0]   seg_pts,
	input  logic [cbst_pkg::STEP_W-1:0] step,
	output logic v_s1,
	input  logic rdy_s1,
	output logic [cbst_pkg::T_W-1:0] t_s1,
	output logic [cbst_pkg::T_W-1:0] u_s1,
	output cbst_pkg::tag_t tag_s1,
	output logic signed [COORD_WIDTH-1:0] coords_s1 [cbst_pkg::NCOORD]
);
	import cbst_pkg::*;

	localparam int IW = (MAX_SEGMENT_POINTS > 1) ? $clog2(MAX_SEGMENT_POINTS) : 1;
	localparam logic [SP_W-1:0] MAXN = SP_W'(MAX_SEGMENT_POINTS);

	logic busy_q;
	logic [T_W-1:0] t_q;
	logic [T_W-1:0] t_nxt;
	logic [T_W:0] t_sum;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] nm1;
	logic signed [COORD_WIDTH-1:0] coords_q [NCOORD];
	logic signed [COORD_WIDTH-1:0] seg_coords [NCOORD];
	logic adv1, issue, is_last, accept;

	assign seg_coords[0]  = seg.p0_x;
	assign seg_coords[1]  = seg.p0_y;
	assign seg_coords[2]  = seg.p0_z;
	assign seg_coords[3]  = seg.p1_x;
	assign seg_coords[4]  = seg.p1_y;
	assign seg_coords[5]  = seg.p1_z;
	assign seg_coords[6]  = seg.p2_x;
	assign seg_coords[7]  = seg.p2_y;
	assign seg_coords[8]  = seg.p2_z;
	assign seg_coords[9]  = seg.p3_x;
	assign seg_coords[10] = seg.p3_y;
	assign seg_coords[11] = seg.p3_z;

	// zero points means one, too many means the maximum
	always_comb begin
		priority if (seg_pts == '0) begin
			nm1 = '0;
		end else if (seg_pts > MAXN) begin
			nm1 = IW'(MAX_SEGMENT_POINTS - 1);
		end else begin
			nm1 = IW'(seg_pts - 1'b1);
		end
	end

	assign adv1    = !v_s1 || rdy_s1;
	assign issue   = busy_q && adv1;
	assign is_last = (idx_q == nm1);
	assign seg.ready = !busy_q || (issue && is_last);
	assign accept  = seg.valid && seg.ready;

	// t saturates at 1.0
	assign t_sum = {1'b0, t_q} + {1'b0, step};
	assign t_nxt = (t_sum > {1'b0, T_ONE}) ? T_ONE : t_sum[T_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			t_q    <= '0;
			idx_q  <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= issue;
			end
			if (accept) begin
				busy_q <= 1'b1;
				t_q    <= '0;
				idx_q  <= '0;
			end else if (issue) begin
				if (is_last) begin
					busy_q <= 1'b0;
					t_q    <= '0;
					idx_q  <= '0;
				end else begin
					t_q   <= t_nxt;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coords_q <= seg_coords;
		end
		if (issue) begin
			t_s1      <= t_q;
			u_s1      <= T_ONE - t_q;
			tag_s1    <= '{idx: IDX_W'(idx_q), last: is_last};
			coords_s1 <= coords_q;
		end
	end

	a_first_point: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && idx_q == '0 && t_q == '0))
		else $error("segment did not start at point zero");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (t_q <= T_ONE))
		else $error("parameter beyond one");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && is_last && !accept) |=> !busy_q)
		else $error("sequencer still busy after last point");

endmodule

>>> sv/cbst_weight.sv
// Cubic Bezier segment tessellator: Bernstein weight pipeline (stages s2, s3).
// Depends on cbst_pkg; takes stage s1 from cbst_seq, feeds cbst_blend.
module cbst_weight #(
	parameter int COORD_WIDTH = cbst_pkg::COORD_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_s1,
	output logic rdy_s1,
	input  logic [cbst_pkg::T_W-1:0] t_s1,
	input  logic [cbst_pkg::T_W-1:0] u_s1,
	input  cbst_pkg::tag_t tag_s1,
	input  logic signed [COORD_WIDTH-1:0] coords_s1 [cbst_pkg::NCOORD],
	output logic v_s3,
	input  logic rdy_s3,
	output logic [cbst_pkg::W_W-1:0] w_s3 [cbst_pkg::NPTS],
	output cbst_pkg::tag_t tag_s3,
	output logic signed [COORD_WIDTH-1:0] coords_s3 [cbst_pkg::NCOORD]
);
	import cbst_pkg::*;

	localparam int SQ_W = 2 * T_W;
	localparam int CU_W = 3 * T_W;

	logic v_s2;
	logic adv2, adv3;
	logic [SQ_W-1:0] uu_s2, tt_s2;
	logic [T_W-1:0] u_s2, t_s2;
	tag_t tag_s2;
	logic signed [COORD_WIDTH-1:0] coords_s2 [NCOORD];
	logic [SQ_W-1:0] uu, tt;
	logic [CU_W-1:0] m0, m1, m2, m3;

	assign adv3   = !v_s3 || rdy_s3;
	assign adv2   = !v_s2 || adv3;
	assign rdy_s1 = adv2;

	assign uu = u_s1 * u_s1;
	assign tt = t_s1 * t_s1;

	assign m0 = uu_s2 * u_s2;
	assign m1 = uu_s2 * t_s2;
	assign m2 = tt_s2 * u_s2;
	assign m3 = tt_s2 * t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			uu_s2     <= uu;
			tt_s2     <= tt;
			u_s2      <= u_s1;
			t_s2      <= t_s1;
			tag_s2    <= tag_s1;
			coords_s2 <= coords_s1;
		end
		if (adv3 && v_s2) begin
			w_s3[0]   <= m0[W_W-1:0];
			w_s3[1]   <= m1[W_W-1:0] + {m1[W_W-2:0], 1'b0};
			w_s3[2]   <= m2[W_W-1:0] + {m2[W_W-2:0], 1'b0};
			w_s3[3]   <= m3[W_W-1:0];
			tag_s3    <= tag_s2;
			coords_s3 <= coords_s2;
		end
	end

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((CU_W'(w_s3[0]) + CU_W'(w_s3[1]) + CU_W'(w_s3[2]) + CU_W'(w_s3[3]))
			== (CU_W'(1) << W_FRAC)))
		else $error("Bernstein weights do not sum to one");

endmodule

>>> sv/cbst_blend.sv
// Cubic Bezier segment tessellator: weighted sum, rounding and saturation (stages s4..s6).
// Depends on cbst_pkg and cbst_pt_if; s6 is the output register.
module cbst_blend #(
	parameter int COORD_WIDTH = cbst_pkg::COORD_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_s3,
	output logic rdy_s3,
	input  logic [cbst_pkg::W_W-1:0] w_s3 [cbst_pkg::NPTS],
	input  cbst_pkg::tag_t tag_s3,
	input  logic signed [COORD_WIDTH-1:0] coords_s3 [cbst_pkg::NCOORD],
	cbst_pt_if.source pt
);
	import cbst_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PH = CW + W_W - W_SPLIT + 1;
	localparam int PL = CW + W_SPLIT + 1;
	localparam int SH = PH + 2;
	localparam int SL = PL + 2;
	localparam int SW = SH + W_SPLIT + 1;
	localparam int QW = SW - W_FRAC;
	localparam logic signed [SW-1:0] RND = SW'(1) <<< (W_FRAC - 1);
	localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};

	logic v_s4, v_s5, v_s6;
	logic adv4, adv5, adv6;
	logic signed [PH-1:0] hi_s4 [NAXIS][NPTS];
	logic signed [PL-1:0] lo_s4 [NAXIS][NPTS];
	logic signed [SH-1:0] sh_s5 [NAXIS];
	logic signed [SL-1:0] sl_s5 [NAXIS];
	tag_t tag_s4, tag_s5, tag_s6;
	logic [CW-1:0] res_s6 [NAXIS];
	logic signed [SW-1:0] full [NAXIS];
	logic [QW-1:0] q [NAXIS];
	logic [NAXIS-1:0] ok;
	logic [CW-1:0] sat [NAXIS];

	assign adv6   = !v_s6 || pt.ready;
	assign adv5   = !v_s5 || adv6;
	assign adv4   = !v_s4 || adv5;
	assign rdy_s3 = adv4;

	// round half up, then floor by 2^48
	always_comb begin
		for (int a = 0; a < NAXIS; a++) begin
			full[a] = (SW'(sh_s5[a]) <<< W_SPLIT) + SW'(sl_s5[a]) + RND;
			q[a]    = full[a][SW-1:W_FRAC];
			ok[a]   = (&q[a][QW-1:CW-1]) | ~(|q[a][QW-1:CW-1]);
			sat[a]  = ok[a] ? q[a][CW-1:0] : (q[a][QW-1] ? MINV : MAXV);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv4) begin
				v_s4 <= v_s3;
			end
			if (adv5) begin
				v_s5 <= v_s4;
			end
			if (adv6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			for (int a = 0; a < NAXIS; a++) begin
				for (int k = 0; k < NPTS; k++) begin
					hi_s4[a][k] <= $signed({1'b0, w_s3[k][W_W-1:W_SPLIT]})
						* coords_s3[k*NAXIS+a];
					lo_s4[a][k] <= $signed({1'b0, w_s3[k][W_SPLIT-1:0]})
						* coords_s3[k*NAXIS+a];
				end
			end
			tag_s4 <= tag_s3;
		end
		if (adv5 && v_s4) begin
			for (int a = 0; a < NAXIS; a++) begin
				sh_s5[a] <= SH'(hi_s4[a][0]) + SH'(hi_s4[a][1])
					+ SH'(hi_s4[a][2]) + SH'(hi_s4[a][3]);
				sl_s5[a] <= SL'(lo_s4[a][0]) + SL'(lo_s4[a][1])
					+ SL'(lo_s4[a][2]) + SL'(lo_s4[a][3]);
			end
			tag_s5 <= tag_s4;
		end
		if (adv6 && v_s5) begin
			res_s6 <= sat;
			tag_s6 <= tag_s5;
		end
	end

	assign pt.valid       = v_s6;
	assign pt.point_x     = res_s6[0];
	assign pt.point_y     = res_s6[1];
	assign pt.point_z     = res_s6[2];
	assign pt.point_index = tag_s6.idx;
	assign pt.last_point  = tag_s6.last;

	// a convex combination of in-range points never needs clamping
	a_no_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (&ok))
		else $error("blended coordinate out of range");

endmodule
